// ===== rtl/csf_pkg.sv =====
// Shared types and constants for the counting semaphore with its wait queue.
`timescale 1ns / 1ps

package csf_pkg;

  // Queue and field sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int MAX_RELEASE = 32;

  localparam int ID_W     = 8;
  localparam int REL_W    = 6;
  localparam int COUNT_W  = 16;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int GRANT_W  = (OCC_W > REL_W) ? OCC_W : REL_W;
  localparam int ID_KEEP  = (ID_BITS < ID_W) ? ID_BITS : ID_W;

  // Register word index (compared with paddr[2])
  localparam logic REG_MAX_COUNT = 1'b0;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_TRY     = 2'd1,
    OP_RELEASE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    K_ACQUIRED = 3'd0,
    K_TRYFAIL  = 3'd1,
    K_QUEUED   = 3'd2,
    K_GRANT    = 3'd3,
    K_ERROR    = 3'd4,
    K_DONE     = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_GRANT,
    S_DONE
  } state_e;

endpackage

// ===== rtl/counting_semaphore_fifo_top.sv =====
// Counting semaphore with a FIFO queue of waiter identifiers held in a RAM.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+-----------------------------------------
//   in       | in_valid_i / in_stall_o      | opcode_i, waiter_id_i, release_count_i
//   out      | out_valid_o / out_stall_i    | kind_o, granted_id_o, count_now_o, last_o
//   cfg      | psel/penable/pwrite/pready   | paddr, pwdata, prdata
//
// Acquire, try acquire, errors and releases with no waiter are answered from the idle state alone.
// A release that grants g waiters steps through the accepting cycle, then per grant
// a wait RAM read and an output state, then the done result.
// Reset clears count, pointers and occupancy at once; the RAM is not cleared.
// A stalled output holds its transaction; the input stalls until it is free.
`timescale 1ns / 1ps

module counting_semaphore_fifo_top import csf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          opcode_i,
  input  logic [ID_W-1:0]     waiter_id_i,
  input  logic [REL_W-1:0]    release_count_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          kind_o,
  output logic [ID_W-1:0]     granted_id_o,
  output logic [COUNT_W-1:0]  count_now_o,
  output logic                last_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [CFG_DW-1:0]   pwdata,
  output logic [CFG_DW-1:0]   prdata,
  output logic                pready
);

  state_e               state_q, state_d;
  logic [COUNT_W-1:0]   max_count_q;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [PTR_W-1:0]     head_q, head_d, tail_q, tail_d;
  logic [OCC_W-1:0]     occ_q, occ_d;
  logic [GRANT_W-1:0]   left_q, left_d;
  logic [COUNT_W-1:0]   done_cnt_q, done_cnt_d;

  logic                 out_valid_q, out_valid_d;
  kind_e                out_kind_q, out_kind_d;
  logic [ID_W-1:0]      out_id_q, out_id_d;
  logic [COUNT_W-1:0]   out_cnt_q, out_cnt_d;
  logic                 out_last_q, out_last_d;

  logic [ID_KEEP-1:0]   mem [QUEUE_DEPTH];
  logic [ID_KEEP-1:0]   rd_q;
  logic                 mem_we, mem_re;

  logic                 out_free, in_take, rel_bad, rel_go;
  logic [COUNT_W:0]     rel_sum;
  logic [GRANT_W-1:0]   rel_n, occ_w, grants;
  logic [ID_KEEP-1:0]   id_keep;
  logic [ID_W-1:0]      id_ext;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_COUNT) ? CFG_DW'(max_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_count_q <= COUNT_W'(1);
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_COUNT) begin
      max_count_q <= pwdata[COUNT_W-1:0];
    end
  end

  // Handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_take    = (state_q == S_IDLE) && in_valid_i && out_free;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);

  // Decode the incoming transaction
  assign id_keep = waiter_id_i[ID_KEEP-1:0];
  assign id_ext  = ID_W'(id_keep);
  assign rel_n   = GRANT_W'(release_count_i);
  assign occ_w   = GRANT_W'(occ_q);
  assign rel_sum = {1'b0, count_q} + (COUNT_W + 1)'(release_count_i);
  assign rel_bad = (release_count_i > REL_W'(MAX_RELEASE)) ||
                   (rel_sum > {1'b0, max_count_q});
  assign grants  = (rel_n < occ_w) ? rel_n : occ_w;
  assign rel_go  = in_take && (opcode_i == OP_RELEASE) && !rel_bad && (grants != '0);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (rel_go) state_d = S_READ;
      S_READ:  state_d = S_GRANT;
      S_GRANT: if (out_free) state_d = (left_q == '0) ? S_DONE : S_READ;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and result selection
  always_comb begin
    count_d     = count_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    left_d      = left_q;
    done_cnt_d  = done_cnt_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_kind_d  = out_kind_q;
    out_id_d    = out_id_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          out_id_d    = '0;
          out_kind_d  = K_ERROR;
          case (opcode_i)
            OP_ACQUIRE: begin
              if (count_q != '0) begin
                count_d    = count_q - COUNT_W'(1);
                out_kind_d = K_ACQUIRED;
                out_id_d   = id_ext;
              end else if (occ_q != OCC_W'(QUEUE_DEPTH)) begin
                mem_we     = 1'b1;
                tail_d     = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
                occ_d      = occ_q + OCC_W'(1);
                out_kind_d = K_QUEUED;
                out_id_d   = id_ext;
              end
            end
            OP_TRY: begin
              out_id_d = id_ext;
              if (count_q != '0) begin
                count_d    = count_q - COUNT_W'(1);
                out_kind_d = K_ACQUIRED;
              end else begin
                out_kind_d = K_TRYFAIL;
              end
            end
            OP_RELEASE: begin
              if (!rel_bad) begin
                done_cnt_d = COUNT_W'(rel_sum - (COUNT_W + 1)'(grants));
                if (grants == '0) begin
                  count_d    = done_cnt_d;
                  out_kind_d = K_DONE;
                end else begin
                  out_valid_d = out_valid_q && out_stall_i;
                  out_kind_d  = out_kind_q;
                  out_id_d    = out_id_q;
                  out_last_d  = out_last_q;
                  left_d      = grants;
                end
              end
            end
            default: ;
          endcase
          out_cnt_d = count_d;
          if (rel_go) out_cnt_d = out_cnt_q;
        end
      end
      S_READ: begin
        // Pop the oldest waiter
        mem_re = 1'b1;
        head_d = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
        occ_d  = occ_q - OCC_W'(1);
        left_d = left_q - GRANT_W'(1);
      end
      S_GRANT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = K_GRANT;
          out_id_d    = ID_W'(rd_q);
          out_cnt_d   = count_q;
          out_last_d  = 1'b0;
        end
      end
      S_DONE: begin
        if (out_free) begin
          count_d     = done_cnt_q;
          out_valid_d = 1'b1;
          out_kind_d  = K_DONE;
          out_id_d    = '0;
          out_cnt_d   = done_cnt_q;
          out_last_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Wait RAM: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[tail_q] <= id_keep;
    if (mem_re) rd_q <= mem[head_q];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    done_cnt_q <= done_cnt_d;
    out_kind_q <= out_kind_d;
    out_id_q   <= out_id_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_kind_q;
  assign granted_id_o = out_id_q;
  assign count_now_o  = out_cnt_q;
  assign last_o       = out_last_q;

endmodule

// ===== rtl/csf_checker.sv =====
// Port-level checker for the counting semaphore, bound to the top level.
`timescale 1ns / 1ps

module csf_checker import csf_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic [1:0]          opcode_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [2:0]          kind_o,
  input logic [ID_W-1:0]     granted_id_o,
  input logic [COUNT_W-1:0]  count_now_o,
  input logic                last_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(count_now_o))
    else $error("stalled output transaction changed");

  // Every accepted transaction other than a release answers in the next cycle
  a_in_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && opcode_i != OP_RELEASE |=> out_valid_o && last_o)
    else $error("accepted transaction produced no final result");

  // Only grants leave the sequence open
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (kind_o != K_GRANT)))
    else $error("last flag does not match result kind");

  // Error and done carry no identifier
  a_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == K_ERROR || kind_o == K_DONE) |-> granted_id_o == '0)
    else $error("error or done result carries an identifier");

endmodule

bind counting_semaphore_fifo_top csf_checker u_csf_checker (.*);

// ===== tb/tb_counting_semaphore_fifo_top.sv =====
// Self-checking testbench for the counting semaphore with its FIFO wait queue.
`timescale 1ns / 1ps

module tb_counting_semaphore_fifo_top import csf_pkg::*;;

  localparam logic [1:0]        OP_BAD         = 2'd3;
  localparam logic [CFG_AW-1:0] ADDR_MAX_COUNT = {REG_MAX_COUNT, 2'b00};
  localparam int                HOLD_CYCLES    = 300;
  localparam int                WATCHDOG_LIMIT = 2000;
  localparam int                TAIL_CYCLES    = 20;

  typedef struct packed {
    kind_e               kind;
    logic [ID_W-1:0]     id;
    logic [COUNT_W-1:0]  units;
    logic                last;
  } reply_t;

  // Track semaphore state and hold the replies still owed by the block
  class semaphore_tracker;
    logic [COUNT_W-1:0] limit;
    logic [COUNT_W-1:0] units;
    logic [ID_W-1:0]    waiters[$];
    reply_t             pending_replies[$];
    int                 mismatches;
    int                 requests;
    int                 replies;
    int                 grants;
    int                 rejects;

    function new();
      limit = 16'd1;
      units = '0;
      mismatches = 0;
      requests = 0;
      replies = 0;
      grants = 0;
      rejects = 0;
    endfunction

    function void set_limit(input logic [COUNT_W-1:0] value);
      limit = value;
    endfunction

    function void owe(input kind_e kind, input logic [ID_W-1:0] id, input logic last);
      reply_t r;
      r.kind = kind;
      r.id = id;
      r.units = units;
      r.last = last;
      pending_replies.push_back(r);
    endfunction

    // Predict the replies of one accepted transaction
    function void accept_request(input logic [1:0] op, input logic [ID_W-1:0] raw_id,
                                 input logic [REL_W-1:0] rel);
      logic [ID_W-1:0] id;
      int              total;
      id = raw_id & ID_W'((1 << ID_KEEP) - 1);
      requests++;
      case (op)
        OP_ACQUIRE: begin
          if (units != 0) begin
            units--;
            owe(K_ACQUIRED, id, 1'b1);
          end else if (waiters.size() >= QUEUE_DEPTH) begin
            owe(K_ERROR, '0, 1'b1);
          end else begin
            waiters.push_back(id);
            owe(K_QUEUED, id, 1'b1);
          end
        end
        OP_TRY: begin
          if (units != 0) begin
            units--;
            owe(K_ACQUIRED, id, 1'b1);
          end else begin
            owe(K_TRYFAIL, id, 1'b1);
          end
        end
        OP_RELEASE: begin
          total = int'(units) + int'(rel);
          if (rel > MAX_RELEASE || total > int'(limit)) begin
            owe(K_ERROR, '0, 1'b1);
          end else begin
            // Hand units to the oldest waiters first, then bank the rest
            for (int u = 0; u < rel; u++) begin
              if (waiters.size() != 0) owe(K_GRANT, waiters.pop_front(), 1'b0);
              else units++;
            end
            owe(K_DONE, '0, 1'b1);
          end
        end
        default: begin
          owe(K_ERROR, '0, 1'b1);
        end
      endcase
    endfunction

    // Compare one accepted reply with the oldest expectation
    function void check_reply(input logic [2:0] kind, input logic [ID_W-1:0] id,
                              input logic [COUNT_W-1:0] cnt, input logic last);
      reply_t exp_r;
      replies++;
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: kind %0d id %0d count %0d last %0d", kind, id, cnt, last);
        mismatches++;
        return;
      end
      exp_r = pending_replies.pop_front();
      if (exp_r.kind == K_GRANT) grants++;
      if (exp_r.kind == K_ERROR) rejects++;
      if (kind !== exp_r.kind) begin
        $error("kind: expected %0d, got %0d", exp_r.kind, kind);
        mismatches++;
      end
      if (id !== exp_r.id) begin
        $error("granted_id: expected %0d, got %0d", exp_r.id, id);
        mismatches++;
      end
      if (cnt !== exp_r.units) begin
        $error("count_now: expected %0d, got %0d", exp_r.units, cnt);
        mismatches++;
      end
      if (last !== exp_r.last) begin
        $error("last: expected %0d, got %0d", exp_r.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         opcode_i = OP_ACQUIRE;
  logic [ID_W-1:0]    waiter_id_i = '0;
  logic [REL_W-1:0]   release_count_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         kind_o;
  logic [ID_W-1:0]    granted_id_o;
  logic [COUNT_W-1:0] count_now_o;
  logic               last_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [CFG_AW-1:0]  paddr = '0;
  logic [CFG_DW-1:0]  pwdata = '0;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;

  semaphore_tracker tracker = new();
  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_req = 1'b0;
  int  quiet_cycles = 0;
  int  settings = 0;

  counting_semaphore_fifo_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .waiter_id_i     (waiter_id_i),
    .release_count_i (release_count_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .granted_id_o    (granted_id_o),
    .count_now_o     (count_now_o),
    .last_o          (last_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #5 clk_i = ~clk_i;

  // Observe both channels and guard against a hung run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        tracker.accept_request(opcode_i, waiter_id_i, release_count_i);
      end
      if (out_valid_o && !out_stall_i) begin
        tracker.check_reply(kind_o, granted_id_o, count_now_o, last_o);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Drive receiver stall; honor a requested long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Offer one transaction, with an optional idle gap first, and wait for acceptance
  task automatic send_request(input logic [1:0] op, input logic [ID_W-1:0] id,
                              input logic [REL_W-1:0] rel);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    waiter_id_i     <= id;
    release_count_i <= rel;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Draw a random transaction weighted toward well-formed traffic
  task automatic send_random();
    int               pick;
    logic [1:0]       op;
    logic [REL_W-1:0] rel;
    pick = $urandom_range(0, 99);
    if (pick < 45) op = OP_ACQUIRE;
    else if (pick < 60) op = OP_TRY;
    else if (pick < 96) op = OP_RELEASE;
    else op = OP_BAD;
    pick = $urandom_range(0, 99);
    if (pick < 70) rel = REL_W'($urandom_range(0, 4));
    else if (pick < 92) rel = REL_W'($urandom_range(5, MAX_RELEASE));
    else rel = REL_W'($urandom_range(MAX_RELEASE + 1, (1 << REL_W) - 1));
    send_request(op, ID_W'($urandom_range(0, 255)), rel);
  endtask

  // Drop valid and wait until every owed reply has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_replies.size() != 0);
  endtask

  // Optionally write max_count, then read it back
  task automatic program_limit(input logic [COUNT_W-1:0] value, input bit do_write);
    if (do_write) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_MAX_COUNT;
      pwdata  <= CFG_DW'(value);
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      tracker.set_limit(value);
      settings++;
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_MAX_COUNT;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[COUNT_W-1:0] !== tracker.limit) begin
      $error("max_count: expected %0d, got %0d", tracker.limit, prdata[COUNT_W-1:0]);
      tracker.mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Configure, set idling, and run a block of random transactions
  task automatic run_phase(input logic [COUNT_W-1:0] value, input int idle, input int stall,
                           input int count);
    drain();
    program_limit(value, 1'b1);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (count) send_random();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset value of max_count, then edge cases at max_count of one
    program_limit(16'd1, 1'b0);
    send_request(OP_TRY, 8'hFF, 6'd0);
    send_request(OP_RELEASE, 8'h00, 6'd0);
    send_request(OP_RELEASE, 8'h00, 6'd1);
    send_request(OP_ACQUIRE, 8'h00, 6'd0);
    send_request(OP_RELEASE, 8'hFF, 6'd63);
    send_request(OP_BAD, 8'h5A, 6'd21);

    // Fill the queue past capacity, then release the largest allowed batch
    drain();
    program_limit(16'd40, 1'b1);
    for (int i = 0; i <= QUEUE_DEPTH; i++) begin
      send_request(OP_ACQUIRE, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : ID_W'(i * 53 + 7), '0);
    end
    send_request(OP_RELEASE, 8'h00, REL_W'(MAX_RELEASE));

    // Lower max_count below the held count
    drain();
    program_limit(16'd4, 1'b1);
    send_request(OP_RELEASE, 8'h00, 6'd0);
    send_request(OP_ACQUIRE, 8'hC3, 6'd0);

    // Random phases under each idling pattern and several limits
    run_phase(16'hFFFF, 0, 0, 70);
    run_phase(16'd1, 50, 0, 70);
    run_phase(16'd8, 0, 50, 70);
    run_phase(16'hFFFF, 15, 15, 70);

    // Hold the receiver off while the sender keeps offering
    drain();
    program_limit(16'd20, 1'b1);
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    repeat (30) send_random();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Checked %0d replies for %0d requests (%0d grants, %0d rejects).",
             tracker.replies, tracker.requests, tracker.grants, tracker.rejects);
    $display("Wrote %0d max_count settings, from 1 up to 65535.", settings);
    if (tracker.mismatches == 0 && tracker.pending_replies.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
